>>> hw/rtl/epmt_pkg.sv
// shared types, constants and register codes for the edge period tachometer
package epmt_pkg;

   localparam int unsigned WindowDepth = 5;
   localparam int unsigned SlotWidth   = $clog2(WindowDepth);
   localparam int unsigned CountWidth  = $clog2(WindowDepth + 1);
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CsrIdxWidth-1:0] CSR_MIN_PERIOD  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_STALE_AGE   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LOST_AGE    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_POLE_COUNT  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_PULLEY      = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_RATE        = 3'd5;

   localparam logic [1:0] STATUS_LOST  = 2'd0;
   localparam logic [1:0] STATUS_STALE = 2'd1;
   localparam logic [1:0] STATUS_FRESH = 2'd2;

   localparam logic       OP_EDGE = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [15:0] AGE_MAX   = 16'hFFFF;
   localparam logic [14:0] RPM_SCALE = 15'd30720;

   typedef struct packed {
      logic        opcode;
      logic [31:0] edge_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] median_ticks;
      logic        freq_valid;
      logic [39:0] freq_q8;
      logic        rpm_valid;
      logic [31:0] rpm_value;
   } rsp_type;

   // snapshot handed from front to back through the job handshake
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] median_ticks;
      logic        freq_valid;
      logic        rpm_valid;
      logic [31:0] rate;
      logic [23:0] pole_ratio;
   } job_type;

endpackage

>>> hw/rtl/edge_period_median_tachometer.sv
// top level of the edge period tachometer with median-of-five filter
// Each word (edge or millisecond tick) gives one result word. The front part
// updates the period ring and age, then finds the upper median by trying one
// ring entry a cycle and hands a snapshot to the back part. The back part runs
// a one-bit-a-cycle restoring divider for the frequency and, when poles and
// ratio are set, for the rpm; it skips the divider when the frequency is not
// valid. One finished result waits in an output register while the front part
// already takes the next word.
module edge_period_median_tachometer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  epmt_pkg::req_type                     req_word,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output epmt_pkg::rsp_type                     rsp_word,
   input  logic                                  csr_write,
   input  logic [epmt_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [epmt_pkg::CsrDataWidth-1:0]     csr_data
);

   logic [31:0]       min_period_ff;
   logic [15:0]       stale_age_ff;
   logic [15:0]       lost_age_ff;
   logic [7:0]        pole_count_ff;
   logic [15:0]       pulley_ff;
   logic [31:0]       rate_ff;
   logic              busy;
   logic              job_valid;
   logic              job_ready;
   epmt_pkg::job_type job_word;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= 32'd98;
         stale_age_ff  <= 16'd200;
         lost_age_ff   <= 16'd800;
         pole_count_ff <= '0;
         pulley_ff     <= '0;
         rate_ff       <= 32'd979592;
      end else if (csr_write) begin
         case (csr_index)
            epmt_pkg::CSR_MIN_PERIOD: min_period_ff <= csr_data;
            epmt_pkg::CSR_STALE_AGE:  stale_age_ff  <= csr_data[15:0];
            epmt_pkg::CSR_LOST_AGE:   lost_age_ff   <= csr_data[15:0];
            epmt_pkg::CSR_POLE_COUNT: pole_count_ff <= csr_data[7:0];
            epmt_pkg::CSR_PULLEY:     pulley_ff     <= csr_data[15:0];
            epmt_pkg::CSR_RATE:       rate_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_full = busy;

   epmt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_push),
      .req_word        (req_word),
      .busy            (busy),
      .job_ready       (job_ready),
      .job_valid       (job_valid),
      .job_word        (job_word),
      .min_period      (min_period_ff),
      .stale_age       (stale_age_ff),
      .lost_age        (lost_age_ff),
      .pole_count      (pole_count_ff),
      .pulley_ratio_q8 (pulley_ff),
      .timebase_rate   (rate_ff)
   );

   epmt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_word  (job_word),
      .job_ready (job_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

>>> hw/rtl/epmt_front.sv
// front part: edge timing state, ring, age, status and median selection
module epmt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  epmt_pkg::req_type                 req_word,
   output logic                              busy,
   input  logic                              job_ready,
   output logic                              job_valid,
   output epmt_pkg::job_type                 job_word,
   input  logic [31:0]                       min_period,
   input  logic [15:0]                       stale_age,
   input  logic [15:0]                       lost_age,
   input  logic [7:0]                        pole_count,
   input  logic [15:0]                       pulley_ratio_q8,
   input  logic [31:0]                       timebase_rate
);

   typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_SEND} state_type;

   state_type                                    state_ff;
   logic                                         seen_ff;
   logic [31:0]                                  last_ff;
   logic [31:0]                                  win_ff [epmt_pkg::WindowDepth];
   logic [epmt_pkg::SlotWidth-1:0]               slot_ff;
   logic [epmt_pkg::CountWidth-1:0]              fill_ff;
   logic [15:0]                                  age_ff;
   logic [epmt_pkg::SlotWidth-1:0]               cand_ff;
   logic [31:0]                                  med_ff;
   logic [1:0]                                   status_in;

   logic [31:0]                                  period;
   logic [31:0]                                  cval;
   logic [epmt_pkg::CountWidth-1:0]              less_cnt;
   logic [epmt_pkg::CountWidth-1:0]              leq_cnt;
   logic [epmt_pkg::CountWidth-1:0]              half;

   assign period = req_word.edge_time - last_ff;
   assign busy   = (state_ff != ST_IDLE);
   assign cval   = win_ff[cand_ff];
   assign half   = fill_ff >> 1;

   // rank the candidate against the filled entries
   always_comb begin
      less_cnt = '0;
      leq_cnt  = '0;
      for (int i = 0; i < epmt_pkg::WindowDepth; i++) begin
         if (i < int'(fill_ff)) begin
            if (win_ff[i] < cval)  less_cnt = less_cnt + 1'b1;
            if (win_ff[i] <= cval) leq_cnt  = leq_cnt + 1'b1;
         end
      end
   end

   // status from age at this point
   always_comb begin
      if (!seen_ff || age_ff >= lost_age) status_in = epmt_pkg::STATUS_LOST;
      else if (age_ff >= stale_age)       status_in = epmt_pkg::STATUS_STALE;
      else                                status_in = epmt_pkg::STATUS_FRESH;
   end

   always_comb begin
      job_word.status       = status_in;
      job_word.median_ticks = med_ff;
      job_word.freq_valid   = (status_in != epmt_pkg::STATUS_LOST) && (fill_ff != '0)
                              && (med_ff != '0);
      job_word.rpm_valid    = job_word.freq_valid && (pole_count != '0)
                              && (pulley_ratio_q8 != '0);
      job_word.rate         = timebase_rate;
      job_word.pole_ratio   = {8'd0, pulley_ratio_q8} * {16'd0, pole_count};
   end
   assign job_valid = (state_ff == ST_SEND);

   // state update, then a one-candidate-a-cycle median search
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= 1'b0;
         last_ff  <= '0;
         slot_ff  <= '0;
         fill_ff  <= '0;
         age_ff   <= '0;
         cand_ff  <= '0;
         med_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  if (req_word.opcode == epmt_pkg::OP_EDGE) begin
                     if (seen_ff) begin
                        if (period >= min_period) begin
                           win_ff[slot_ff] <= period;
                           slot_ff <= (slot_ff == epmt_pkg::SlotWidth'(epmt_pkg::WindowDepth - 1))
                                      ? '0 : slot_ff + 1'b1;
                           if (fill_ff != epmt_pkg::CountWidth'(epmt_pkg::WindowDepth))
                              fill_ff <= fill_ff + 1'b1;
                           age_ff <= '0;
                        end
                     end else begin
                        seen_ff <= 1'b1;
                        age_ff  <= '0;
                     end
                     last_ff <= req_word.edge_time;
                  end else if (age_ff != epmt_pkg::AGE_MAX) begin
                     age_ff <= age_ff + 1'b1;
                  end
                  cand_ff  <= '0;
                  med_ff   <= '0;
                  state_ff <= ST_RANK;
               end
            end
            ST_RANK: begin
               if (fill_ff == '0) begin
                  state_ff <= ST_SEND;
               end else if (less_cnt <= half && leq_cnt > half) begin
                  med_ff   <= cval;
                  state_ff <= ST_SEND;
               end else begin
                  cand_ff <= cand_ff + 1'b1;
               end
            end
            ST_SEND: begin
               if (job_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/epmt_div.sv
// back part: restoring divider for frequency and rpm, with result output register
module epmt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  epmt_pkg::job_type     job_word,
   output logic                  job_ready,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output epmt_pkg::rsp_type     rsp_word
);

   typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_FREQ, ST_RPM, ST_DONE} state_type;

   state_type         state_ff;
   epmt_pkg::job_type job_ff;
   logic [55:0]       den_ff;
   logic [46:0]       num_ff;
   logic [46:0]       quo_ff;
   logic [56:0]       rem_ff;
   logic [5:0]        cnt_ff;
   logic [39:0]       freq_ff;
   logic              out_full_ff;
   epmt_pkg::rsp_type out_ff;

   logic [56:0]       rem_shift;
   logic [56:0]       rem_sub;
   logic              fits;

   assign rem_shift = {rem_ff[55:0], num_ff[46]};
   assign rem_sub   = rem_shift - {1'b0, den_ff};
   assign fits      = !rem_sub[56];
   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_empty = !out_full_ff;
   assign rsp_word  = out_ff;

   // one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         // output register fill and drain
         if (state_ff == ST_DONE && (!out_full_ff || rsp_pop)) out_full_ff <= 1'b1;
         else if (rsp_pop && out_full_ff)                       out_full_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_word;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (!job_ff.freq_valid) begin
                  freq_ff  <= '0;
                  quo_ff   <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  num_ff   <= {7'd0, job_ff.rate, 8'd0};
                  den_ff   <= {24'd0, job_ff.median_ticks};
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= 6'd47;
                  state_ff <= ST_FREQ;
               end
            end
            ST_FREQ, ST_RPM: begin
               if (cnt_ff != 6'd1) begin
                  num_ff <= num_ff << 1;
                  quo_ff <= {quo_ff[45:0], fits};
                  rem_ff <= fits ? rem_sub : rem_shift;
                  cnt_ff <= cnt_ff - 1'b1;
               end else if (state_ff == ST_RPM) begin
                  quo_ff   <= {quo_ff[45:0], fits};
                  state_ff <= ST_DONE;
               end else begin
                  freq_ff <= {quo_ff[38:0], fits};
                  if (job_ff.rpm_valid) begin
                     num_ff   <= job_ff.rate * {32'd0, epmt_pkg::RPM_SCALE};
                     den_ff   <= job_ff.median_ticks * {32'd0, job_ff.pole_ratio};
                     rem_ff   <= '0;
                     quo_ff   <= '0;
                     cnt_ff   <= 6'd47;
                     state_ff <= ST_RPM;
                  end else begin
                     quo_ff   <= '0;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (!out_full_ff || rsp_pop) begin
                  out_ff.status       <= job_ff.status;
                  out_ff.median_ticks <= job_ff.median_ticks;
                  out_ff.freq_valid   <= job_ff.freq_valid;
                  out_ff.freq_q8      <= freq_ff;
                  out_ff.rpm_valid    <= job_ff.rpm_valid;
                  out_ff.rpm_value    <= (quo_ff[46:32] != '0) ? 32'hFFFF_FFFF : quo_ff[31:0];
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hw/rtl/epmt_checker.sv
// port-level checks for the tachometer, bound to the top level
module epmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input epmt_pkg::rsp_type rsp_word
);

   // status never shows the unused code
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.status <= epmt_pkg::STATUS_FRESH)
      else $error("bad status code");

   // rpm valid only with a valid frequency
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.rpm_valid |-> rsp_word.freq_valid)
      else $error("rpm valid without frequency");

   // a lost status never carries a valid frequency
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.status == epmt_pkg::STATUS_LOST |-> !rsp_word.freq_valid)
      else $error("valid frequency while lost");

   // an accepted word makes the input side busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> req_full)
      else $error("input not busy after accept");

   // a waiting result holds until it is popped
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting result changed");

endmodule

bind edge_period_median_tachometer epmt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);

>>> bench/edge_period_median_tachometer_test.sv
// testbench for the edge period tachometer: directed and random words checked against a predictor
`timescale 1ns / 1ps

module edge_period_median_tachometer_test;

   // scoreboard: tachometer state model and queue of expected result words
   class tach_scoreboard;
      logic [31:0] min_period, rate;
      logic [15:0] stale_age, lost_age, pulley;
      logic [7:0]  poles;
      bit          seen_edge;
      logic [31:0] last_time;
      logic [31:0] ring [epmt_pkg::WindowDepth];
      int unsigned slot, filled;
      logic [15:0] age;
      epmt_pkg::rsp_type pending [$];
      int unsigned errors, words_in, words_out, fresh_seen, stale_seen, lost_seen, rpm_seen;

      function new();
         min_period = 32'd98; stale_age = 16'd200; lost_age = 16'd800;
         poles = 8'd0; pulley = 16'd0; rate = 32'd979592;
         seen_edge = 0; last_time = '0; slot = 0; filled = 0; age = '0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function void write_reg(logic [epmt_pkg::CsrIdxWidth-1:0] idx, logic [31:0] val);
         case (idx)
            epmt_pkg::CSR_MIN_PERIOD: min_period = val;
            epmt_pkg::CSR_STALE_AGE:  stale_age = val[15:0];
            epmt_pkg::CSR_LOST_AGE:   lost_age = val[15:0];
            epmt_pkg::CSR_POLE_COUNT: poles = val[7:0];
            epmt_pkg::CSR_PULLEY:     pulley = val[15:0];
            epmt_pkg::CSR_RATE:       rate = val;
            default: ;
         endcase
      endfunction

      // upper median of filled ring entries
      function logic [31:0] ring_median();
         logic [31:0] buf_q [$];
         for (int i = 0; i < filled; i++) buf_q.push_back(ring[i]);
         if (filled == 0) return '0;
         buf_q.sort();
         return buf_q[filled / 2];
      endfunction

      // note an accepted input word and predict its result
      function void note_input(epmt_pkg::req_type w);
         epmt_pkg::rsp_type r;
         logic [31:0] period;
         logic [63:0] den, q;
         r = '0;
         words_in++;
         if (w.opcode == epmt_pkg::OP_EDGE) begin
            if (seen_edge) begin
               period = w.edge_time - last_time;
               if (period >= min_period) begin
                  ring[slot] = period;
                  slot = (slot + 1) % epmt_pkg::WindowDepth;
                  if (filled < epmt_pkg::WindowDepth) filled++;
                  age = '0;
               end
            end else begin
               seen_edge = 1;
               age = '0;
            end
            last_time = w.edge_time;
         end else if (age != epmt_pkg::AGE_MAX) begin
            age++;
         end
         if (!seen_edge || age >= lost_age) r.status = epmt_pkg::STATUS_LOST;
         else if (age >= stale_age) r.status = epmt_pkg::STATUS_STALE;
         else r.status = epmt_pkg::STATUS_FRESH;
         r.median_ticks = ring_median();
         if (r.status != epmt_pkg::STATUS_LOST && filled > 0 && r.median_ticks != 0) begin
            r.freq_valid = 1;
            r.freq_q8 = 40'(({32'd0, rate} << 8) / {32'd0, r.median_ticks});
            if (poles != 0 && pulley != 0) begin
               r.rpm_valid = 1;
               den = 64'(r.median_ticks) * 64'(poles) * 64'(pulley);
               q = (64'(rate) * 64'(epmt_pkg::RPM_SCALE)) / den;
               r.rpm_value = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               rpm_seen++;
            end
         end
         case (r.status)
            epmt_pkg::STATUS_LOST:  lost_seen++;
            epmt_pkg::STATUS_STALE: stale_seen++;
            default:                fresh_seen++;
         endcase
         pending.push_back(r);
      endfunction

      // compare an accepted result word with the oldest prediction
      function void check_result(epmt_pkg::rsp_type got);
         epmt_pkg::rsp_type e;
         words_out++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
         end
         if (got.median_ticks !== e.median_ticks) begin
            $display("%0t: median exp %0d got %0d", $time, e.median_ticks, got.median_ticks);
            errors++;
         end
         if (got.freq_valid !== e.freq_valid) begin
            $display("%0t: freq_valid exp %0d got %0d", $time, e.freq_valid, got.freq_valid);
            errors++;
         end
         if (got.freq_q8 !== e.freq_q8) begin
            $display("%0t: freq_q8 exp %0d got %0d", $time, e.freq_q8, got.freq_q8); errors++;
         end
         if (got.rpm_valid !== e.rpm_valid) begin
            $display("%0t: rpm_valid exp %0d got %0d", $time, e.rpm_valid, got.rpm_valid);
            errors++;
         end
         if (got.rpm_value !== e.rpm_value) begin
            $display("%0t: rpm exp %0d got %0d", $time, e.rpm_value, got.rpm_value); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   epmt_pkg::req_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   epmt_pkg::rsp_type rsp_word;
   logic csr_write = 0;
   logic [epmt_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [epmt_pkg::CsrDataWidth-1:0] csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   logic [31:0] clock_now = '0;
   tach_scoreboard sb = new();

   always #2 clock = ~clock;

   edge_period_median_tachometer u_dut (
      .clock, .reset, .req_push, .req_full, .req_word,
      .rsp_empty, .rsp_pop, .rsp_word, .csr_write, .csr_index, .csr_data
   );

   // result side: random stall, check on accept
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_word);
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // send one word, with random idle cycles beforehand
   task automatic send_word(logic op, logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_push <= 1;
      req_word <= '{opcode: op, edge_time: t};
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_input('{opcode: op, edge_time: t});
      req_push <= 0;
      @(posedge clock);
   endtask

   task automatic send_edge(logic [31:0] step);
      clock_now += step;
      send_word(epmt_pkg::OP_EDGE, clock_now);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_word(epmt_pkg::OP_TICK, $urandom);
   endtask

   // wait until every predicted word is back, then let the block settle
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(logic [epmt_pkg::CsrIdxWidth-1:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // one random phase: plausible edge trains, short periods and random edge times mixed with tick runs
   task automatic random_phase(int n);
      int unsigned k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) send_edge($urandom_range(3000, 50));
         else if (k < 55) send_edge($urandom_range(120));
         else if (k < 60) send_word(epmt_pkg::OP_EDGE, $urandom);
         else if (k < 97) send_ticks($urandom_range(4, 1));
         else send_ticks($urandom_range(60, 10));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: ticks before first edge, first edge, short and long periods, wrap
      send_ticks(2);
      send_word(epmt_pkg::OP_EDGE, 32'hFFFF_FFF0);
      clock_now = 32'hFFFF_FFF0;
      send_edge(32'd50);
      send_edge(32'd98);
      send_edge(32'd97);
      send_edge(32'd1000);
      send_edge(32'd400);
      send_edge(32'd2000);
      send_edge(32'd700);
      send_ticks(3);
      drain();
      write_csr(epmt_pkg::CSR_POLE_COUNT, 32'd255);
      write_csr(epmt_pkg::CSR_PULLEY, 32'hFFFF);
      write_csr(epmt_pkg::CSR_STALE_AGE, 32'd2);
      write_csr(epmt_pkg::CSR_LOST_AGE, 32'd4);
      send_edge(32'd1000);
      send_ticks(5);
      send_word(epmt_pkg::OP_EDGE, 32'hFFFF_FFFF);
      send_word(epmt_pkg::OP_EDGE, 32'h0000_0000);
      drain();
      // zero min period, zero and max rate, small poles
      write_csr(epmt_pkg::CSR_MIN_PERIOD, 32'd0);
      write_csr(epmt_pkg::CSR_RATE, 32'hFFFF_FFFF);
      write_csr(epmt_pkg::CSR_POLE_COUNT, 32'd1);
      write_csr(epmt_pkg::CSR_PULLEY, 32'd1);
      write_csr(epmt_pkg::CSR_LOST_AGE, 32'hFFFF);
      write_csr(epmt_pkg::CSR_STALE_AGE, 32'hFFFF);
      send_edge(32'd0);
      send_edge(32'd0);
      send_edge(32'd1);
      send_edge(32'hFFFF_FFFF);
      drain();
      write_csr(epmt_pkg::CSR_RATE, 32'd0);
      send_edge(32'd5);
      drain();
      write_csr(epmt_pkg::CSR_LOST_AGE, 32'd0);
      send_edge(32'd500);
      drain();

      // random phases under several idling settings and register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 47; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 47; end
            default: begin send_idle_pct = 35; pop_stall_pct = 35; end
         endcase
         write_csr(epmt_pkg::CSR_MIN_PERIOD, (ph == 7) ? 32'hFFFF_FFFF : $urandom_range(150));
         write_csr(epmt_pkg::CSR_STALE_AGE, $urandom_range(30));
         write_csr(epmt_pkg::CSR_LOST_AGE, (ph == 6) ? 32'hFFFF : $urandom_range(80, 10));
         write_csr(epmt_pkg::CSR_POLE_COUNT, (ph == 0) ? 32'd0 : $urandom_range(255));
         write_csr(epmt_pkg::CSR_PULLEY, $urandom_range(65535));
         write_csr(epmt_pkg::CSR_RATE, (ph == 5) ? 32'd1 : $urandom);
         random_phase(29);
         drain();
      end
      // final edge after the random phases
      send_idle_pct = 0;
      pop_stall_pct = 0;
      send_edge(32'd300);
      drain();

      $display("covered %0d words: %0d fresh, %0d stale, %0d lost, %0d with rpm",
               sb.words_in, sb.fresh_seen, sb.stale_seen, sb.lost_seen, sb.rpm_seen);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
